// ----- rtl/iee_pkg.sv -----
`timescale 1ns / 1ps

package iee_pkg;

    localparam int DATA_WIDTH   = 64;
    localparam int VALUE_WIDTH  = 64;
    localparam int CH_WIDTH     = 8;
    localparam int STATUS_WIDTH = 2;
    localparam int DEC_BASE     = 10;

    typedef logic [STATUS_WIDTH-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DIVZERO  = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_WIDTH-1:0] CH_STAR  = 8'h2a;
    localparam logic [CH_WIDTH-1:0] CH_SLASH = 8'h2f;

    typedef struct packed {
        logic [CH_WIDTH-1:0] ch;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        t_status                status;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic div;
    } t_md_ctrl;

    typedef struct packed {
        logic    done;
        t_status err;
    } t_md_stat;

    // The first error of an expression wins.
    function automatic t_status f_merge(input t_status cur, input t_status nxt);
        return (cur != ST_OK) ? cur : nxt;
    endfunction

    function automatic logic f_is_digit(input logic [CH_WIDTH-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

// ----- rtl/iee_stream_if.sv -----
`timescale 1ns / 1ps

interface iee_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/iee_muldiv.sv -----
`timescale 1ns / 1ps

module iee_muldiv #(
    parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iee_pkg::t_md_ctrl      i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_a,
    input  logic [DATA_WIDTH-1:0]  i_b,
    output iee_pkg::t_md_stat      o_stat,
    output logic [DATA_WIDTH-1:0]  o_result
);

    localparam int CW = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_RUN  = 3'b010,
        MD_FIN  = 3'b100
    } t_md_state;

    t_md_state             r_state, n_state;
    logic                  r_div, n_div;
    logic                  r_neg, n_neg;
    logic                  r_dz, n_dz;
    logic [DATA_WIDTH-1:0] r_dvsr, n_dvsr;
    logic [DATA_WIDTH-1:0] r_hi, n_hi;
    logic [DATA_WIDTH-1:0] r_lo, n_lo;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_done, n_done;
    iee_pkg::t_status      r_err, n_err;
    logic [DATA_WIDTH-1:0] r_result, n_result;

    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic [DATA_WIDTH:0]   w_mul_sum;
    logic [DATA_WIDTH+1:0] w_trial;
    logic [DATA_WIDTH-1:0] w_neg_lo;
    logic                  w_mul_ovf;

    assign w_mag_a   = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b   = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_dvsr} : '0);
    assign w_trial   = {1'b0, r_hi, r_lo[DATA_WIDTH-1]} - {2'b00, r_dvsr};
    assign w_neg_lo  = ~r_lo + 1'b1;
    assign w_mul_ovf = (r_hi != '0) ||
                       (r_neg ? (r_lo[DATA_WIDTH-1] && (|r_lo[DATA_WIDTH-2:0]))
                              : r_lo[DATA_WIDTH-1]);

    always_comb begin
        n_state  = r_state;
        n_div    = r_div;
        n_neg    = r_neg;
        n_dz     = r_dz;
        n_dvsr   = r_dvsr;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_count  = r_count;
        n_done   = 1'b0;
        n_err    = r_err;
        n_result = r_result;
        case (r_state)
            MD_IDLE: begin
                if (i_ctrl.start) begin
                    n_div   = i_ctrl.div;
                    n_neg   = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                    n_dz    = i_ctrl.div && (i_b == '0);
                    n_hi    = '0;
                    n_count = CW'(DATA_WIDTH - 1);
                    if (i_ctrl.div) begin
                        n_lo   = w_mag_a;
                        n_dvsr = w_mag_b;
                    end else begin
                        n_lo   = w_mag_b;
                        n_dvsr = w_mag_a;
                    end
                    n_state = (i_ctrl.div && (i_b == '0)) ? MD_FIN : MD_RUN;
                end
            end
            MD_RUN: begin
                if (r_div) begin
                    if (!w_trial[DATA_WIDTH+1]) begin
                        n_hi = w_trial[DATA_WIDTH-1:0];
                        n_lo = {r_lo[DATA_WIDTH-2:0], 1'b1};
                    end else begin
                        n_hi = {r_hi[DATA_WIDTH-2:0], r_lo[DATA_WIDTH-1]};
                        n_lo = {r_lo[DATA_WIDTH-2:0], 1'b0};
                    end
                end else begin
                    n_hi = w_mul_sum[DATA_WIDTH:1];
                    n_lo = {w_mul_sum[0], r_lo[DATA_WIDTH-1:1]};
                end
                n_count = r_count - 1'b1;
                if (r_count == '0) begin
                    n_state = MD_FIN;
                end
            end
            MD_FIN: begin
                n_done = 1'b1;
                if (r_dz) begin
                    n_result = '0;
                    n_err    = iee_pkg::ST_DIVZERO;
                end else if (r_div) begin
                    n_result = r_neg ? w_neg_lo : r_lo;
                    n_err    = (!r_neg && r_lo[DATA_WIDTH-1]) ? iee_pkg::ST_OVERFLOW
                                                              : iee_pkg::ST_OK;
                end else begin
                    n_result = r_neg ? w_neg_lo : r_lo;
                    n_err    = w_mul_ovf ? iee_pkg::ST_OVERFLOW : iee_pkg::ST_OK;
                end
                n_state = MD_IDLE;
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div    <= n_div;
        r_neg    <= n_neg;
        r_dz     <= n_dz;
        r_dvsr   <= n_dvsr;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_count  <= n_count;
        r_err    <= n_err;
        r_result <= n_result;
    end

    assign o_stat.done = r_done;
    assign o_stat.err  = r_err;
    assign o_result    = r_result;

endmodule

// ----- rtl/infix_expression_evaluator.sv -----
// A space that is not last is taken without the multiply/divide unit; any other character waits
// for the radix-2 multiply/divide unit (one bit per cycle), which skips its run on a division by zero.
// A character flagged as last adds the final fold (a last space needs only that fold), and then
// the result register is loaded and holds the result until it is taken.
// Synchronous active-low reset clears the number, sum, modes and status, sets the product
// term to one and empties the output register.
`timescale 1ns / 1ps

module infix_expression_evaluator #(
    parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iee_stream_if.sink    i_in,
    iee_stream_if.source  o_out
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIGIT = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_TERM  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state                             r_state, n_state;
    logic [DATA_WIDTH-1:0]              r_number, n_number;
    logic [DATA_WIDTH-1:0]              r_sum, n_sum;
    logic [DATA_WIDTH-1:0]              r_product, n_product;
    logic                               r_divide, n_divide;
    logic                               r_subtract, n_subtract;
    iee_pkg::t_status                   r_error, n_error;
    logic [iee_pkg::CH_WIDTH-1:0]       r_ch, n_ch;
    logic                               r_last, n_last;
    logic                               r_start, n_start;
    logic                               r_op_div, n_op_div;
    logic [DATA_WIDTH-1:0]              r_op_a, n_op_a;
    logic [DATA_WIDTH-1:0]              r_op_b, n_op_b;
    logic [DATA_WIDTH-1:0]              r_final, n_final;
    iee_pkg::t_status                   r_final_status, n_final_status;
    logic                               r_out_valid, n_out_valid;
    logic [iee_pkg::VALUE_WIDTH-1:0]    r_out_value, n_out_value;
    iee_pkg::t_status                   r_out_status, n_out_status;

    iee_pkg::t_md_ctrl                  w_md_ctrl;
    iee_pkg::t_md_stat                  w_md_stat;
    logic [DATA_WIDTH-1:0]              w_md_result;
    logic                               w_in_accept;
    logic [DATA_WIDTH-1:0]              w_digit;
    logic [DATA_WIDTH:0]                w_digit_res;
    logic [DATA_WIDTH:0]                w_sum_res;
    iee_pkg::t_status                   w_err_md;
    iee_pkg::t_status                   w_err_digit;
    iee_pkg::t_status                   w_err_sum;
    logic                               w_is_addsub;
    logic                               w_is_muldiv;

    // Returns the overflow flag above the wrapped sum or difference.
    function automatic logic [DATA_WIDTH:0] f_addsub(
        input logic [DATA_WIDTH-1:0] a,
        input logic [DATA_WIDTH-1:0] b,
        input logic                  sub
    );
        logic [DATA_WIDTH-1:0] r;
        logic                  ovf;
        r   = sub ? (a - b) : (a + b);
        ovf = sub ? ((a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) & (a[DATA_WIDTH-1] ^ r[DATA_WIDTH-1]))
                  : (~(a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) & (a[DATA_WIDTH-1] ^ r[DATA_WIDTH-1]));
        return {ovf, r};
    endfunction

    iee_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_md_ctrl),
        .i_a      (r_op_a),
        .i_b      (r_op_b),
        .o_stat   (w_md_stat),
        .o_result (w_md_result)
    );

    assign w_md_ctrl.start = r_start;
    assign w_md_ctrl.div   = r_op_div;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_accept = i_in.valid && (r_state == ST_IDLE);

    assign w_digit     = DATA_WIDTH'(8'(r_ch - iee_pkg::CH_ZERO));
    assign w_digit_res = f_addsub(w_md_result, w_digit, 1'b0);
    assign w_sum_res   = f_addsub(r_sum, w_md_result, r_subtract);
    assign w_err_md    = iee_pkg::f_merge(r_error, w_md_stat.err);
    assign w_err_digit = iee_pkg::f_merge(w_err_md, w_digit_res[DATA_WIDTH] ?
                                          iee_pkg::ST_OVERFLOW : iee_pkg::ST_OK);
    assign w_err_sum   = iee_pkg::f_merge(w_err_md, w_sum_res[DATA_WIDTH] ?
                                          iee_pkg::ST_OVERFLOW : iee_pkg::ST_OK);
    assign w_is_addsub = (r_ch == iee_pkg::CH_PLUS) || (r_ch == iee_pkg::CH_MINUS);
    assign w_is_muldiv = (r_ch == iee_pkg::CH_STAR) || (r_ch == iee_pkg::CH_SLASH);

    always_comb begin
        n_state        = r_state;
        n_number       = r_number;
        n_sum          = r_sum;
        n_product      = r_product;
        n_divide       = r_divide;
        n_subtract     = r_subtract;
        n_error        = r_error;
        n_ch           = r_ch;
        n_last         = r_last;
        n_start        = 1'b0;
        n_op_div       = r_op_div;
        n_op_a         = r_op_a;
        n_op_b         = r_op_b;
        n_final        = r_final;
        n_final_status = r_final_status;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_value    = r_out_value;
        n_out_status   = r_out_status;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_ch   = i_in.payload.ch;
                    n_last = i_in.payload.last;
                    if (iee_pkg::f_is_digit(i_in.payload.ch)) begin
                        n_start  = 1'b1;
                        n_op_div = 1'b0;
                        n_op_a   = r_number;
                        n_op_b   = DATA_WIDTH'(iee_pkg::DEC_BASE);
                        n_state  = ST_DIGIT;
                    end else if (i_in.payload.ch != iee_pkg::CH_SPACE ||
                                 i_in.payload.last) begin
                        n_start  = 1'b1;
                        n_op_div = r_divide;
                        n_op_a   = r_product;
                        n_op_b   = r_number;
                        n_state  = (i_in.payload.ch != iee_pkg::CH_SPACE) ? ST_FOLD : ST_TERM;
                    end
                end
            end
            ST_DIGIT: begin
                if (w_md_stat.done) begin
                    n_number = w_digit_res[DATA_WIDTH-1:0];
                    n_error  = w_err_digit;
                    if (r_last) begin
                        n_start  = 1'b1;
                        n_op_div = r_divide;
                        n_op_a   = r_product;
                        n_op_b   = w_digit_res[DATA_WIDTH-1:0];
                        n_state  = ST_TERM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FOLD: begin
                if (w_md_stat.done) begin
                    n_number  = '0;
                    n_product = w_md_result;
                    n_error   = w_err_md;
                    if (w_is_addsub) begin
                        n_sum      = w_sum_res[DATA_WIDTH-1:0];
                        n_error    = w_err_sum;
                        n_subtract = (r_ch == iee_pkg::CH_MINUS);
                        n_product  = DATA_WIDTH'(1);
                        n_divide   = 1'b0;
                    end else if (w_is_muldiv) begin
                        n_divide = (r_ch == iee_pkg::CH_SLASH);
                    end
                    if (r_last) begin
                        n_start  = 1'b1;
                        n_op_div = n_divide;
                        n_op_a   = n_product;
                        n_op_b   = '0;
                        n_state  = ST_TERM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TERM: begin
                if (w_md_stat.done) begin
                    n_final        = w_sum_res[DATA_WIDTH-1:0];
                    n_final_status = w_err_sum;
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = iee_pkg::VALUE_WIDTH'($signed(r_final));
                    n_out_status = r_final_status;
                    n_number     = '0;
                    n_sum        = '0;
                    n_product    = DATA_WIDTH'(1);
                    n_divide     = 1'b0;
                    n_subtract   = 1'b0;
                    n_error      = iee_pkg::ST_OK;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_number    <= '0;
            r_sum       <= '0;
            r_product   <= DATA_WIDTH'(1);
            r_divide    <= 1'b0;
            r_subtract  <= 1'b0;
            r_error     <= iee_pkg::ST_OK;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_number    <= n_number;
            r_sum       <= n_sum;
            r_product   <= n_product;
            r_divide    <= n_divide;
            r_subtract  <= n_subtract;
            r_error     <= n_error;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch           <= n_ch;
        r_last         <= n_last;
        r_op_div       <= n_op_div;
        r_op_a         <= n_op_a;
        r_op_b         <= n_op_b;
        r_final        <= n_final;
        r_final_status <= n_final_status;
        r_out_value    <= n_out_value;
        r_out_status   <= n_out_status;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload.value  = r_out_value;
    assign o_out.payload.status = r_out_status;

endmodule

// ----- tb/infix_expression_evaluator_test.sv -----
`timescale 1ns / 1ps

module infix_expression_evaluator_test;

    import iee_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 2 * (DATA_WIDTH + 4) + 16;
    localparam int N_PHASES     = 6;
    localparam int IDLE_PLAN [N_PHASES]  = '{0, 80, 0, 12, 0, 12};
    localparam int STALL_PLAN [N_PHASES] = '{0, 0, 80, 12, 0, 12};
    localparam int ITEM_PLAN [N_PHASES]  = '{350, 300, 300, 300, 200, 80};
    localparam int HOLD_PHASE = 4;

    localparam logic [63:0] W_MASK = (DATA_WIDTH == 64) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
    localparam logic [63:0] W_SIGN = 64'd1 << (DATA_WIDTH - 1);

    typedef struct {
        logic [63:0] number;
        logic [63:0] sum;
        logic [63:0] term;
        logic        dividing;
        logic        subtracting;
        t_status     status;
    } t_calc;

    logic i_clk;
    logic i_rst_n;

    iee_stream_if #(.t_payload(t_in_item))  in_if ();
    iee_stream_if #(.t_payload(t_out_item)) out_if ();

    infix_expression_evaluator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_in_item  chars_to_send [$];
    t_out_item expected_results [$];
    t_calc     calc;

    int n_queued;
    int n_accepted;
    int n_mismatches;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    logic hold_request;
    logic hold_used;

    function automatic logic [63:0] sext_w(input logic [63:0] x);
        x &= W_MASK;
        if ((x & W_SIGN) != 0) begin
            x |= ~W_MASK;
        end
        return x;
    endfunction

    function automatic void note_status(input t_status code);
        if (calc.status == ST_OK) begin
            calc.status = code;
        end
    endfunction

    function automatic logic [63:0] magnitude_of(input logic [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] add_w(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic [63:0] flags;
        r = a + b;
        flags = (a ^ r) & (b ^ r);
        if (flags[63] || sext_w(r) != r) begin
            note_status(ST_OVERFLOW);
        end
        return sext_w(r);
    endfunction

    function automatic logic [63:0] sub_w(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic [63:0] flags;
        r = a - b;
        flags = (a ^ b) & (a ^ r);
        if (flags[63] || sext_w(r) != r) begin
            note_status(ST_OVERFLOW);
        end
        return sext_w(r);
    endfunction

    function automatic logic [63:0] mul_w(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        logic [63:0]  limit;
        logic [63:0]  r;
        full = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
        limit = (a[63] ^ b[63]) ? W_SIGN : W_SIGN - 64'd1;
        if (full[127:64] != 0 || full[63:0] > limit) begin
            note_status(ST_OVERFLOW);
        end
        r = a * b;
        return sext_w(r);
    endfunction

    function automatic logic [63:0] div_w(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic        neg;
        if (b == 0) begin
            note_status(ST_DIVZERO);
            return 64'd0;
        end
        q = magnitude_of(a) / magnitude_of(b);
        neg = a[63] ^ b[63];
        if (!neg && q > W_SIGN - 64'd1) begin
            note_status(ST_OVERFLOW);
        end
        return sext_w(neg ? -q : q);
    endfunction

    function automatic logic [63:0] fold_term();
        return calc.dividing ? div_w(calc.term, calc.number) : mul_w(calc.term, calc.number);
    endfunction

    function automatic void clear_calc();
        calc.number      = 64'd0;
        calc.sum         = 64'd0;
        calc.term        = 64'd1;
        calc.dividing    = 1'b0;
        calc.subtracting = 1'b0;
        calc.status      = ST_OK;
    endfunction

    // Advances the calculator by one character and queues the result on the last one.
    function automatic void evaluate_char(input t_in_item item);
        logic [63:0] scaled;
        logic [63:0] total;
        if (item.ch >= CH_ZERO && item.ch <= CH_NINE) begin
            scaled = mul_w(calc.number, 64'(DEC_BASE));
            calc.number = add_w(scaled, 64'(item.ch - CH_ZERO));
        end else if (item.ch != CH_SPACE) begin
            calc.term = fold_term();
            calc.number = 64'd0;
            if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
                calc.sum = calc.subtracting ? sub_w(calc.sum, calc.term)
                                            : add_w(calc.sum, calc.term);
                calc.subtracting = (item.ch == CH_MINUS);
                calc.term = 64'd1;
                calc.dividing = 1'b0;
            end else if (item.ch == CH_STAR || item.ch == CH_SLASH) begin
                calc.dividing = (item.ch == CH_SLASH);
            end
        end
        if (item.last) begin
            total = fold_term();
            total = calc.subtracting ? sub_w(calc.sum, total) : add_w(calc.sum, total);
            expected_results.push_back('{value: sext_w(total), status: calc.status});
            clear_calc();
        end
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic is_last);
        chars_to_send.push_back('{ch: c, last: is_last});
        n_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], i == s.len() - 1);
        end
    endtask

    // Mostly well-formed expressions with numbers of varied length, some noise.
    task automatic queue_random_expression();
        logic [7:0] text [$];
        int terms;
        int len;
        int r;
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(1, 8);
            repeat (len) text.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(9) == 0) begin
                text.push_back(CH_MINUS);
            end
            terms = $urandom_range(1, 6);
            for (int t = 0; t < terms; t++) begin
                if ($urandom_range(99) < 8) begin
                    text.push_back(CH_SPACE);
                end
                r = $urandom_range(99);
                len = (r < 55) ? $urandom_range(1, 2) :
                      (r < 80) ? $urandom_range(3, 6) :
                      (r < 93) ? $urandom_range(7, 12) : $urandom_range(13, 21);
                if ($urandom_range(99) < 8) begin
                    text.push_back(CH_ZERO);
                end else begin
                    repeat (len) text.push_back(8'(CH_ZERO + $urandom_range(9)));
                end
                if ($urandom_range(3) == 0) begin
                    text.push_back(CH_SPACE);
                end
                if ($urandom_range(24) == 0) begin
                    text.push_back(8'($urandom_range(255)));
                end
                if (t < terms - 1 || $urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0: text.push_back(CH_PLUS);
                        1: text.push_back(CH_MINUS);
                        2: text.push_back(CH_STAR);
                        default: text.push_back(CH_SLASH);
                    endcase
                end
            end
        end
        for (int i = 0; i < text.size(); i++) begin
            queue_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        n_mismatches++;
        if (n_mismatches <= 10) begin
            $display("%s: expected value %0d status %0d, got value %0d status %0d",
                     what, $signed(want.value), want.status, $signed(got.value), got.status);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int phase_start;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        hold_request = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        clear_calc();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty input, bytes outside the grammar, division by zero, a leading minus,
        // every operator with an operator at the end, and a stray letter inside a term.
        queue_text(" ");
        queue_char(8'h00, 1'b0);
        queue_char(8'hff, 1'b1);
        queue_text("0");
        queue_text("7/0");
        queue_text("-9/2");
        queue_text("12*3-8/3+");
        queue_text("5a3");

        for (int p = 0; p < N_PHASES; p++) begin
            while (n_accepted != n_queued || expected_results.size() != 0) begin
                @(posedge i_clk);
            end
            sender_idle_pct <= IDLE_PLAN[p];
            receiver_stall_pct <= STALL_PLAN[p];
            hold_request <= (p == HOLD_PHASE);
            phase_start = n_queued;
            while (n_queued - phase_start < ITEM_PLAN[p]) begin
                queue_random_expression();
            end
        end

        while (n_accepted != n_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_mismatches++;
        end
        if (n_mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                evaluate_char(in_if.payload);
                n_accepted <= n_accepted + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (chars_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.payload <= chars_to_send.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("Unexpected transaction", '0, out_if.payload);
            end else begin
                want = expected_results.pop_front();
                if (out_if.payload.value !== want.value
                        || out_if.payload.status !== want.status) begin
                    report_mismatch("Mismatch", want, out_if.payload);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        n_queued = 0;
        n_accepted = 0;
        n_mismatches = 0;
        cycle_count = 0;
        hold_left = 0;
        hold_used = 1'b0;
    end

endmodule

// ----- sim.f -----
rtl/iee_pkg.sv
rtl/iee_stream_if.sv
rtl/iee_muldiv.sv
rtl/infix_expression_evaluator.sv
tb/infix_expression_evaluator_test.sv
